>>> rtl/core/pst_pkg.sv
package pst_pkg;

  // field widths
  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 15;
  localparam int EVAL_W   = 16;
  localparam int ERR_W    = 16;
  localparam int SPEED_W  = 16;
  localparam int STEER_W  = 16;
  localparam int THR_W    = 16;
  localparam int TOTAL_W  = 48;
  localparam int CNT_W    = 17;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_START = 3'd4;

  // accumulator of the three terms at q.26, plus rounding headroom
  localparam int ACC_W       = 45;
  localparam int RND_W       = ACC_W + 1;
  localparam int ROUND_SHIFT = 12;
  localparam int ITERM_SHIFT = 42;

  // throttle constants, q1.15 and q8.8
  localparam int THROTTLE_BASE  = 9830;
  localparam int THROTTLE_SMALL = 33;
  localparam int SPEED_MIN      = 1280;
  localparam int SQ_ROUND       = 4096;
  localparam int SQ_SHIFT       = 13;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // serial multiplier step count
  localparam int LEN_W = 7;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } mul_ctl_t;

endpackage

>>> rtl/core/pst_smul.sv
module pst_smul #(
  parameter int A_W = 24,
  parameter int B_W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pst_pkg::mul_ctl_t     ctl,
  input  logic signed [A_W-1:0] a,
  input  logic signed [B_W-1:0] b,
  output logic                  done,
  output logic [A_W+B_W:0]      raw
);
  import pst_pkg::*;

  logic signed [A_W:0]   hi_r, hi_nxt;
  logic [B_W-1:0]        lo_r, lo_nxt;
  logic signed [A_W-1:0] a_r, a_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  last;
  logic signed [A_W+1:0] a_ext;
  logic signed [A_W+1:0] addend;
  logic signed [A_W+1:0] sum;

  // sign bit of the multiplier carries negative weight
  always_comb begin
    last   = (cnt_r == len_r - LEN_W'(1));
    a_ext  = {{2{a_r[A_W-1]}}, a_r};
    addend = '0;
    if (lo_r[0]) begin
      addend = last ? -a_ext : a_ext;
    end
    sum = {hi_r[A_W], hi_r} + addend;
  end

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    a_nxt    = a_r;
    len_nxt  = len_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      hi_nxt   = '0;
      lo_nxt   = b;
      a_nxt    = a;
      len_nxt  = ctl.len;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = sum[A_W+1:1];
      lo_nxt  = {sum[0], lo_r[B_W-1:1]};
      cnt_nxt = cnt_r + LEN_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    a_r   <= a_nxt;
    len_r <= len_nxt;
  end

  assign done = done_r;
  assign raw  = {hi_r, lo_r};

endmodule

>>> rtl/core/pid_steer_throttle_control.sv
// pid steering and throttle controller with steer clamp. each request carries a
// cross-track error (q5.10) and a speed (q8.8) and gives one result: clamped steer
// (q1.14), throttle (q1.15), the windowed squared-error total and the step count.
// one request is in flight at a time. kp*e, kd*de, ki*integral and steer^2 go in
// that order through one bit-serial multiplier that takes one multiplier bit per
// cycle. e^2 runs in a second serial unit alongside kp*e. the result sits in an
// output register, so the next request is taken while it waits downstream.
module pid_steer_throttle_control #(
  parameter int INTEGRAL_BITS = 32,
  parameter int SUM_BITS      = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pst_pkg::ERR_W-1:0]  in_cross_track_error,
  input  logic [pst_pkg::SPEED_W-1:0]       in_vehicle_speed,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pst_pkg::STEER_W-1:0] out_steer_out,
  output logic [pst_pkg::THR_W-1:0]         out_throttle_out,
  output logic [pst_pkg::TOTAL_W-1:0]       out_error_total,
  output logic                              out_total_valid,
  output logic [pst_pkg::CNT_W-1:0]         out_step_count,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [pst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pst_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pst_pkg::*;

  // multiplier operand width covers the error difference and the integrator
  localparam int MW      = (INTEGRAL_BITS > ERR_W + 1) ? INTEGRAL_BITS : ERR_W + 1;
  localparam int RW      = GAIN_W + 1 + MW;
  localparam int PI_W    = GAIN_W + 1 + INTEGRAL_BITS;
  localparam int PE      = (PI_W > ACC_W) ? PI_W : ACC_W;
  localparam int SW_W    = RND_W - ROUND_SHIFT;
  localparam int ESQ_W   = 2 * ERR_W - 1;
  localparam int SUM_EXT = (SUM_BITS > TOTAL_W) ? SUM_BITS : TOTAL_W;
  localparam int SQ_W    = 2 * STEER_W;

  localparam logic signed [PE-1:0] ILIM =
    {{(PE-ITERM_SHIFT-1){1'b0}}, 1'b1, {ITERM_SHIFT{1'b0}}};

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PROP   = 3'd1;
  localparam logic [2:0] S_DERIV  = 3'd2;
  localparam logic [2:0] S_INTEG  = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_SQUARE = 3'd5;
  localparam logic [2:0] S_HOLD   = 3'd6;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [LIMIT_W-1:0]       steer_limit_r;
  logic [EVAL_W-1:0]        eval_start_r;

  // controller state
  logic [2:0]                      state_r, state_nxt;
  logic signed [ERR_W-1:0]         prev_r, prev_nxt;
  logic                            first_r, first_nxt;
  logic signed [INTEGRAL_BITS-1:0] integ_r, integ_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0]             ssum_r, ssum_nxt;
  logic                            win_r, win_nxt;

  // per-request working registers
  logic signed [ERR_W:0]     d_r, d_nxt;
  logic [SPEED_W-1:0]        speed_r, speed_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [STEER_W-1:0] steer_r, steer_nxt;
  logic [THR_W-1:0]          thr_r, thr_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [STEER_W-1:0] out_steer_r;
  logic [THR_W-1:0]          out_thr_r;
  logic [TOTAL_W-1:0]        out_total_r;
  logic                      out_tvalid_r;
  logic [CNT_W-1:0]          out_cnt_r;
  logic                      out_load;

  // multiplier hookup
  mul_ctl_t                 main_ctl, sq_ctl;
  logic signed [GAIN_W-1:0] a_main;
  logic signed [MW-1:0]     b_main;
  logic                     main_done, sq_done;
  logic [RW-1:0]            main_raw;
  logic [2*ERR_W:0]         sq_raw;

  // datapath signals
  logic accept;
  logic signed [ERR_W-1:0]         prev_sel;
  logic signed [ERR_W:0]           d_c;
  logic signed [INTEGRAL_BITS:0]   integ_sum;
  logic signed [INTEGRAL_BITS-1:0] integ_sat;
  logic [CNT_W-1:0]                cnt_inc;
  logic [CNT_W-1:0]                win_end;
  logic                            win_c;
  logic signed [GAIN_W+ERR_W:0]    prod_p;
  logic signed [GAIN_W+ERR_W+1:0]  prod_d;
  logic signed [PI_W-1:0]          prod_i;
  logic signed [PE-1:0]            prod_i_ext, iterm;
  logic signed [RND_W-1:0]         rnd;
  logic signed [SW_W-1:0]          steer_wide, lim_w, neg_lim;
  logic signed [STEER_W-1:0]       steer_c;
  logic [SQ_W-1:0]                 sq_round;
  logic [SQ_W-SQ_SHIFT-1:0]        sq_q;
  logic signed [SQ_W-SQ_SHIFT:0]   thr_diff;
  logic [THR_W-1:0]                thr_floor, thr_c;
  logic [ESQ_W-1:0]                esq;
  logic [SUM_BITS:0]               ssum_add;
  logic [SUM_EXT-1:0]              ssum_ext;
  logic                            tvalid_c;
  logic [TOTAL_W-1:0]              total_c;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // configuration writes, unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      steer_limit_r <= LIMIT_W'(16384);
      eval_start_r  <= EVAL_W'(500);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN_P:     gain_p_r      <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:     gain_i_r      <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:     gain_d_r      <= cfg_data[GAIN_W-1:0];
        CFG_STEER_LIM:  steer_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_EVAL_START: eval_start_r  <= cfg_data[EVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // front end, evaluated at accept
  always_comb begin
    // first sample loads previous error so the derivative term is zero
    prev_sel  = first_r ? in_cross_track_error : prev_r;
    d_c       = (ERR_W+1)'(in_cross_track_error) - (ERR_W+1)'(prev_sel);

    // integrator saturates at the signed bounds
    integ_sum = (INTEGRAL_BITS+1)'(integ_r) + (INTEGRAL_BITS+1)'(in_cross_track_error);
    integ_sat = integ_sum[INTEGRAL_BITS-1:0];
    if (integ_sum[INTEGRAL_BITS] != integ_sum[INTEGRAL_BITS-1]) begin
      integ_sat = integ_sum[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                                           : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    end

    // step counter sticks at full scale, window is open strictly between n and 2n
    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + CNT_W'(1);
    win_end = {eval_start_r, 1'b0};
    win_c   = (cnt_inc > CNT_W'(eval_start_r)) && (cnt_inc < win_end);
  end

  // ---------------------------------------------------------------------------
  // product extraction: after m steps the product sits at the top of the window
  assign prod_p = main_raw[RW-1 -: GAIN_W+ERR_W+1];
  assign prod_d = main_raw[RW-1 -: GAIN_W+ERR_W+2];
  assign prod_i = main_raw[RW-1 -: PI_W];

  always_comb begin
    // integral term clamped to +/- 2^42 at q.26
    prod_i_ext = PE'(prod_i);
    iterm      = prod_i_ext;
    if (prod_i_ext > ILIM) begin
      iterm = ILIM;
    end else if (prod_i_ext < -ILIM) begin
      iterm = -ILIM;
    end

    // negate, round half up to q1.14, then clamp
    rnd        = RND_W'(2048) - RND_W'(acc_r);
    steer_wide = rnd[RND_W-1:ROUND_SHIFT];
    lim_w      = SW_W'(steer_limit_r);
    neg_lim    = -lim_w;
    if (steer_wide > lim_w) begin
      steer_c = lim_w[STEER_W-1:0];
    end else if (steer_wide < neg_lim) begin
      steer_c = neg_lim[STEER_W-1:0];
    end else begin
      steer_c = steer_wide[STEER_W-1:0];
    end

    // throttle from the rounded steer square
    sq_round  = prod_p[SQ_W-1:0] + SQ_W'(SQ_ROUND);
    sq_q      = sq_round[SQ_W-1:SQ_SHIFT];
    thr_diff  = (SQ_W-SQ_SHIFT+1)'(THROTTLE_BASE) - $signed({1'b0, sq_q});
    thr_floor = thr_diff[SQ_W-SQ_SHIFT] ? '0 : thr_diff[THR_W-1:0];
    if ((thr_floor < THR_W'(THROTTLE_SMALL)) && (speed_r > SPEED_W'(SPEED_MIN))) begin
      thr_c = thr_floor;
    end else begin
      thr_c = THR_W'(THROTTLE_BASE);
    end

    // squared error accumulation, saturating
    esq      = sq_raw[ESQ_W-1:0];
    ssum_add = {1'b0, ssum_r} + (SUM_BITS+1)'(esq);

    // total is reported once the window has closed
    tvalid_c = (cnt_r >= win_end);
    ssum_ext = SUM_EXT'(ssum_r);
    total_c  = '0;
    if (tvalid_c) begin
      total_c = (ssum_ext > SUM_EXT'(TOTAL_MAX)) ? TOTAL_MAX : ssum_ext[TOTAL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_nxt  = state_r;
    prev_nxt   = prev_r;
    first_nxt  = first_r;
    integ_nxt  = integ_r;
    cnt_nxt    = cnt_r;
    win_nxt    = win_r;
    d_nxt      = d_r;
    speed_nxt  = speed_r;
    acc_nxt    = acc_r;
    steer_nxt  = steer_r;
    thr_nxt    = thr_r;
    out_load   = 1'b0;

    main_ctl.start = 1'b0;
    main_ctl.len   = LEN_W'(ERR_W);
    a_main         = '0;
    b_main         = '0;
    sq_ctl.start   = 1'b0;
    sq_ctl.len     = LEN_W'(ERR_W);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // kp*e in the shared unit, e^2 alongside
          main_ctl.start = 1'b1;
          a_main         = gain_p_r;
          b_main         = MW'(in_cross_track_error);
          sq_ctl.start   = 1'b1;
          prev_nxt       = in_cross_track_error;
          first_nxt      = 1'b0;
          d_nxt          = d_c;
          integ_nxt      = integ_sat;
          cnt_nxt        = cnt_inc;
          win_nxt        = win_c;
          speed_nxt      = in_vehicle_speed;
          state_nxt      = S_PROP;
        end
      end
      S_PROP: begin
        if (main_done) begin
          acc_nxt        = ACC_W'(prod_p);
          main_ctl.start = 1'b1;
          main_ctl.len   = LEN_W'(ERR_W + 1);
          a_main         = gain_d_r;
          b_main         = MW'(d_r);
          state_nxt      = S_DERIV;
        end
      end
      S_DERIV: begin
        if (main_done) begin
          acc_nxt        = acc_r + ACC_W'(prod_d);
          main_ctl.start = 1'b1;
          main_ctl.len   = LEN_W'(INTEGRAL_BITS);
          a_main         = gain_i_r;
          b_main         = MW'(integ_r);
          state_nxt      = S_INTEG;
        end
      end
      S_INTEG: begin
        if (main_done) begin
          acc_nxt   = acc_r + iterm[ACC_W-1:0];
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        // steer squared through the same unit
        steer_nxt      = steer_c;
        main_ctl.start = 1'b1;
        main_ctl.len   = LEN_W'(STEER_W);
        a_main         = GAIN_W'(steer_c);
        b_main         = MW'(steer_c);
        state_nxt      = S_SQUARE;
      end
      S_SQUARE: begin
        if (main_done) begin
          thr_nxt   = thr_c;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ssum_nxt = ssum_r;
    if (sq_done && win_r) begin
      ssum_nxt = ssum_add[SUM_BITS] ? '1 : ssum_add[SUM_BITS-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // serial multipliers
  pst_smul #(
    .A_W (GAIN_W),
    .B_W (MW)
  ) u_mul_main (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (main_ctl),
    .a     (a_main),
    .b     (b_main),
    .done  (main_done),
    .raw   (main_raw)
  );

  pst_smul #(
    .A_W (ERR_W),
    .B_W (ERR_W)
  ) u_mul_esq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sq_ctl),
    .a     (in_cross_track_error),
    .b     (in_cross_track_error),
    .done  (sq_done),
    .raw   (sq_raw)
  );

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      first_r     <= 1'b1;
      integ_r     <= '0;
      cnt_r       <= '0;
      ssum_r      <= '0;
      win_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      first_r     <= first_nxt;
      integ_r     <= integ_nxt;
      cnt_r       <= cnt_nxt;
      ssum_r      <= ssum_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    speed_r <= speed_nxt;
    acc_r   <= acc_nxt;
    steer_r <= steer_nxt;
    thr_r   <= thr_nxt;
    if (out_load) begin
      out_steer_r  <= steer_r;
      out_thr_r    <= thr_r;
      out_total_r  <= total_c;
      out_tvalid_r <= tvalid_c;
      out_cnt_r    <= cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_steer_out    = out_steer_r;
  assign out_throttle_out = out_thr_r;
  assign out_error_total  = out_total_r;
  assign out_total_valid  = out_tvalid_r;
  assign out_step_count   = out_cnt_r;

endmodule

>>> rtl/core/pst_checker.sv
module pst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pst_pkg::THR_W-1:0]     out_throttle_out,
  input logic [pst_pkg::TOTAL_W-1:0]   out_error_total,
  input logic                          out_total_valid
);
  import pst_pkg::*;

  // one request at a time: an accepted request blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in flight");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  // total reads zero until the window has closed
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_total_valid) |-> (out_error_total == '0))
    else $error("error total shown before it is ready");

  // throttle is either the base value or a small value
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_throttle_out == THR_W'(THROTTLE_BASE)) ||
                   (out_throttle_out < THR_W'(THROTTLE_SMALL))))
    else $error("throttle outside its two bands");

endmodule

bind pid_steer_throttle_control pst_checker u_pst_checker (.*);

>>> sim/steer_sb_pkg.sv
package steer_sb_pkg;
  import pst_pkg::*;

  // instance sizes used by the bench, kept at the block defaults
  localparam int INTEG_BITS  = 32;
  localparam int SQ_SUM_BITS = 48;

  localparam longint INTEG_MAX   = (longint'(1) << (INTEG_BITS - 1)) - 1;
  localparam longint INTEG_MIN   = -INTEG_MAX - 1;
  localparam longint SQ_SUM_MAX  = (longint'(1) << SQ_SUM_BITS) - 1;
  localparam longint ITERM_BOUND = longint'(1) << ITERM_SHIFT;
  localparam longint COUNT_MAX   = (longint'(1) << CNT_W) - 1;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer;
    logic [THR_W-1:0]          throttle;
    logic [TOTAL_W-1:0]        total;
    logic                      total_valid;
    logic [CNT_W-1:0]          step_count;
  } command_t;

  class steer_throttle_scoreboard;
    longint   gain_p, gain_i, gain_d, steer_limit, eval_start;
    longint   prev_error, integrator, step_count, err_sq_sum;
    bit       first_sample;
    command_t expected_commands[$];
    int       mismatches, commands_seen, clamped, small_throttle, totals_seen;

    function new();
      gain_p       = 0;
      gain_i       = 0;
      gain_d       = 0;
      steer_limit  = 16384;
      eval_start   = 500;
      prev_error   = 0;
      integrator   = 0;
      step_count   = 0;
      err_sq_sum   = 0;
      first_sample = 1'b1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic signed [GAIN_W-1:0] g;
      g = data[GAIN_W-1:0];
      case (idx)
        CFG_GAIN_P:     gain_p = g;
        CFG_GAIN_I:     gain_i = g;
        CFG_GAIN_D:     gain_d = g;
        CFG_STEER_LIM:  steer_limit = data[LIMIT_W-1:0];
        CFG_EVAL_START: eval_start = data[EVAL_W-1:0];
        default: ;
      endcase
    endfunction

    // one command per accepted sample
    function void note_sample(logic signed [ERR_W-1:0] err, logic [SPEED_W-1:0] speed);
      longint   e, d, acc, iterm, mag, steer, sq, thr, win_end, add;
      command_t c;
      e = err;
      if (first_sample) begin
        prev_error   = e;
        first_sample = 1'b0;
      end
      d          = e - prev_error;
      prev_error = e;

      integrator += e;
      if (integrator > INTEG_MAX) integrator = INTEG_MAX;
      if (integrator < INTEG_MIN) integrator = INTEG_MIN;

      // integral term saturates at the q.26 bound
      mag = (gain_i < 0 ? -gain_i : gain_i) * (integrator < 0 ? -integrator : integrator);
      if (mag > ITERM_BOUND) begin
        iterm = ((gain_i < 0) != (integrator < 0)) ? -ITERM_BOUND : ITERM_BOUND;
      end else begin
        iterm = gain_i * integrator;
      end

      acc   = gain_p * e + gain_d * d + iterm;
      steer = ((longint'(1) << (ROUND_SHIFT - 1)) - acc) >>> ROUND_SHIFT;
      if (steer > steer_limit || steer < -steer_limit) clamped++;
      if (steer > steer_limit) steer = steer_limit;
      if (steer < -steer_limit) steer = -steer_limit;

      sq  = (steer * steer + SQ_ROUND) >>> SQ_SHIFT;
      thr = THROTTLE_BASE - sq;
      if (thr < 0) thr = 0;
      if (thr < THROTTLE_SMALL && speed > SPEED_MIN) begin
        small_throttle++;
      end else begin
        thr = THROTTLE_BASE;
      end

      if (step_count < COUNT_MAX) step_count++;
      win_end = 2 * eval_start;
      if (step_count > eval_start && step_count < win_end) begin
        add = e * e;
        if (add > SQ_SUM_MAX - err_sq_sum) err_sq_sum = SQ_SUM_MAX;
        else err_sq_sum += add;
      end

      c.steer       = steer[STEER_W-1:0];
      c.throttle    = thr[THR_W-1:0];
      c.total_valid = (step_count >= win_end);
      c.total       = '0;
      if (c.total_valid) begin
        totals_seen++;
        if (err_sq_sum > longint'(TOTAL_MAX)) c.total = TOTAL_MAX;
        else c.total = err_sq_sum[TOTAL_W-1:0];
      end
      c.step_count = step_count[CNT_W-1:0];
      expected_commands.push_back(c);
    endfunction

    function void check_command(command_t got);
      command_t want;
      commands_seen++;
      if (expected_commands.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("error: command with no sample pending: steer %0d throttle %0d count %0d",
                   got.steer, got.throttle, got.step_count);
        return;
      end
      want = expected_commands.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("error: command %0d expected steer %0d thr %0d total %0d valid %0b count %0d",
                   commands_seen, want.steer, want.throttle, want.total, want.total_valid,
                   want.step_count);
          $display("       got                steer %0d thr %0d total %0d valid %0b count %0d",
                   got.steer, got.throttle, got.total, got.total_valid, got.step_count);
        end
      end
    endfunction

    function int pending();
      return expected_commands.size();
    endfunction
  endclass

endpackage

>>> sim/pid_steer_throttle_control_tb.sv
module pid_steer_throttle_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;
  import steer_sb_pkg::*;

  // run shape
  localparam int PHASE_SAMPLES = 100;
  localparam int RANDOM_PHASES = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  // drain covers a request from accept to result, plus some margin
  localparam int DRAIN_CYCLES  = INTEG_BITS + 55 + 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_EVAL_START + 1'b1;
  localparam logic [GAIN_W-1:0]    GAIN_MAX  = {1'b0, {(GAIN_W-1){1'b1}}};
  localparam logic [GAIN_W-1:0]    GAIN_MIN  = {1'b1, {(GAIN_W-1){1'b0}}};
  localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  // 1.0 in q1.14
  localparam logic [LIMIT_W-1:0]   LIMIT_ONE = 15'd16384;

  typedef enum int {SEQ_SMOOTH, SEQ_DRIFT, SEQ_EXTREME, SEQ_NOISE} seq_kind_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [ERR_W-1:0]    in_cross_track_error;
  logic [SPEED_W-1:0]         in_vehicle_speed;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [STEER_W-1:0]  out_steer_out;
  logic [THR_W-1:0]           out_throttle_out;
  logic [TOTAL_W-1:0]         out_error_total;
  logic                       out_total_valid;
  logic [CNT_W-1:0]           out_step_count;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  // idle odds in percent, changed by the main sequence between phases
  int send_idle_pct;
  int recv_idle_pct;
  // one-shot request for a long output hold-off
  bit hold_request;
  int settings_applied;

  steer_throttle_scoreboard steering_check;

  pid_steer_throttle_control #(
    .INTEGRAL_BITS (INTEG_BITS),
    .SUM_BITS      (SQ_SUM_BITS)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cross_track_error (in_cross_track_error),
    .in_vehicle_speed     (in_vehicle_speed),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_steer_out        (out_steer_out),
    .out_throttle_out     (out_throttle_out),
    .out_error_total      (out_error_total),
    .out_total_valid      (out_total_valid),
    .out_step_count       (out_step_count),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driving tasks: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // one register write; the enable stays up so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    steering_check.set_register(idx, data);
  endtask

  task automatic close_config();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // full register set; bits above the limit and window fields carry junk
  task automatic apply_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] limit,
                                input logic [EVAL_W-1:0] eval_n);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_STEER_LIM, {junk[CFG_DATA_W-1:LIMIT_W], limit});
    write_reg(CFG_EVAL_START, {junk[CFG_DATA_W-1:EVAL_W], eval_n});
    close_config();
    settings_applied++;
  endtask

  // offer one sample, idling first at random, and hold it until the request is taken
  task automatic send_sample(input logic signed [ERR_W-1:0] err, input logic [SPEED_W-1:0] speed);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_cross_track_error <= err;
    in_vehicle_speed     <= speed;
    do @(posedge clk); while (in_stall);
    steering_check.note_sample(err, speed);
  endtask

  task automatic finish_samples();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // the block is idle once every command has come back
  task automatic wait_idle();
    while (steering_check.pending() != 0) @(posedge clk);
  endtask

  // random register set, with extremes and windows placed around the step count
  task automatic random_settings();
    logic [GAIN_W-1:0]  gains[3];
    logic [LIMIT_W-1:0] limit;
    logic [EVAL_W-1:0]  eval_n;
    longint             c;
    for (int g = 0; g < 3; g++) begin
      case ($urandom_range(5))
        0: gains[g] = '0;
        1: gains[g] = GAIN_MAX;
        2: gains[g] = GAIN_MIN;
        3: gains[g] = GAIN_W'($urandom);
        // within +/-1.0, so the steer often stays inside the clamp
        default: gains[g] = GAIN_W'($urandom_range(0, 1 << 17) - (1 << 16));
      endcase
    end
    case ($urandom_range(4))
      0: limit = '0;
      1: limit = '1;
      // clamp level where the kept throttle crosses its small threshold
      2: limit = LIMIT_W'($urandom_range(8900, 9000));
      default: limit = LIMIT_W'($urandom);
    endcase
    c = steering_check.step_count;
    case ($urandom_range(5))
      0: eval_n = '0;
      1: eval_n = '1;
      2: eval_n = EVAL_W'($urandom);
      // window opens a little later
      3: eval_n = EVAL_W'(c + $urandom_range(1, 20));
      // window closes within the phase, and may already be open
      default: eval_n = EVAL_W'((c + $urandom_range(2, 80)) / 2);
    endcase
    apply_settings(gains[0], gains[1], gains[2], limit, eval_n);
  endtask

  // runs of smooth tracking, same-sign drift (winds up the integrator),
  // field extremes and plain noise; speeds sit near the 5.0 threshold, at the extremes or anywhere
  task automatic run_random_phase(input int n, input bit with_hold);
    seq_kind_t               kind;
    int                      run_len;
    bit                      drift_neg;
    longint                  walk;
    logic signed [ERR_W-1:0] err;
    logic [SPEED_W-1:0]      speed;
    kind      = SEQ_NOISE;
    run_len   = 0;
    drift_neg = 1'b0;
    err       = '0;
    for (int k = 0; k < n; k++) begin
      if (run_len == 0) begin
        kind      = seq_kind_t'($urandom_range(SEQ_NOISE));
        run_len   = $urandom_range(5, 30);
        drift_neg = 1'($urandom_range(1));
      end
      run_len--;
      case (kind)
        SEQ_SMOOTH: begin
          walk = longint'(err) + longint'($urandom_range(2048)) - 1024;
          if (walk > ERR_MAX) walk = ERR_MAX;
          if (walk < ERR_MIN) walk = ERR_MIN;
          err = walk[ERR_W-1:0];
        end
        SEQ_DRIFT: begin
          err = ERR_W'($urandom_range(16384, 32767));
          if (drift_neg) err = -err;
        end
        SEQ_EXTREME: begin
          case ($urandom_range(4))
            0: err = ERR_MIN;
            1: err = ERR_MAX;
            2: err = '0;
            3: err = 16'sd1;
            default: err = -16'sd1;
          endcase
        end
        default: err = ERR_W'($urandom);
      endcase
      case ($urandom_range(3))
        0: speed = SPEED_W'(SPEED_MIN - 1 + $urandom_range(2));
        1: speed = $urandom_range(1) ? '1 : '0;
        default: speed = SPEED_W'($urandom);
      endcase
      // hold the output long enough that the block fills and stalls its input
      if (with_hold && k == 20) hold_request = 1'b1;
      send_sample(err, speed);
    end
    finish_samples();
  endtask

  // ---------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------

  // stall driver: random odds, or a counted hold-off when one is requested
  initial begin : recv_stall
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // every taken result is checked against the oldest expected command
  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        steering_check.check_command(command_t'({out_steer_out, out_throttle_out,
                                                 out_error_total, out_total_valid,
                                                 out_step_count}));
    end
  end

  // ends the run when no request moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("pid_steer_throttle_control test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    steering_check       = new();
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_cross_track_error = '0;
    in_vehicle_speed     = '0;
    cfg_wr_en            = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    send_idle_pct        = 20;
    recv_idle_pct        = 69;
    hold_request         = 1'b0;
    settings_applied     = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first samples against the reset clamp and window: only the p and d gains
    // move, and the derivative must stay zero on the very first sample
    write_reg(CFG_GAIN_P, GAIN_MAX);
    write_reg(CFG_GAIN_D, GAIN_MIN);
    close_config();
    send_sample(ERR_MAX, '1);
    send_sample(ERR_MIN, SPEED_W'(SPEED_MIN + 1));
    send_sample('0, SPEED_W'(SPEED_MIN));
    finish_samples();
    wait_idle();

    // unused register indexes take junk and must change nothing
    for (int i = CFG_FIRST_UNUSED; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    // widest clamp, tiny window that closes after four steps
    apply_settings(GAIN_MAX, '0, GAIN_MIN, '1, 16'd2);
    send_sample(ERR_MIN, '0);
    send_sample(ERR_MAX, '1);
    send_sample('0, SPEED_W'(SPEED_MIN + 1));
    send_sample(16'sd1, SPEED_W'(SPEED_MIN));
    send_sample(-16'sd1, '1);
    finish_samples();
    wait_idle();

    // empty window (total valid at once); full-scale errors push the
    // integral term past its saturation bound
    apply_settings('0, GAIN_MAX, '0, LIMIT_ONE, '0);
    for (int k = 0; k < 17; k++) send_sample(ERR_MAX, SPEED_W'($urandom));
    finish_samples();
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // sender idles lightly first, then heavily, then nobody idles
      if (p == 2) begin
        send_idle_pct = 69;
        recv_idle_pct = 20;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 1) apply_settings(GAIN_MIN, GAIN_MIN, GAIN_MAX, '0, '1);
      else random_settings();
      run_random_phase(PHASE_SAMPLES, p == 0);
      wait_idle();
    end

    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d commands checked over %0d register sets, %0d mismatches",
             steering_check.commands_seen, settings_applied, steering_check.mismatches);
    $display("summary: %0d clamped steers, %0d small throttles, %0d with the total reported",
             steering_check.clamped, steering_check.small_throttle, steering_check.totals_seen);
    if (steering_check.mismatches == 0 && steering_check.pending() == 0) begin
      $display("pid_steer_throttle_control test passed");
    end else begin
      $display("pid_steer_throttle_control test failed");
    end
    $finish;
  end

endmodule
